[src/dmsc_pkg.sv]
package dmsc_pkg;

   localparam int MaxWidth      = 2048;
   localparam int MaxHeight     = 2048;
   localparam int SampleWidth   = 8;
   localparam int DimWidth      = 12;
   localparam int ColWidth      = $clog2(MaxWidth);
   localparam int RowWidth      = $clog2(MaxHeight);
   localparam int LineSlots     = 4;
   localparam int SlotWidth     = $clog2(LineSlots);
   localparam int WinCols       = 4;
   localparam int CurCols       = 3;
   localparam int QueueDepth    = 4;
   localparam int PtrWidth      = $clog2(QueueDepth);
   localparam int CountWidth    = $clog2(QueueDepth + 1);
   localparam int CsrIndexWidth = 2;

   localparam logic [DimWidth-1:0] WidthReset  = DimWidth'(640);
   localparam logic [DimWidth-1:0] HeightReset = DimWidth'(480);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FRAME_WIDTH  = 0,
      CSR_FRAME_HEIGHT = 1
   } csr_index_type;

   typedef logic [SampleWidth-1:0] sample_type;

   // One finished 2x2 cell: origin, mode and the neighborhood it needs.
   // Rows: t = y-1, m = y, n = y+1, u = y+2.
   typedef struct packed {
      logic [ColWidth-1:0] x;
      logic [RowWidth-1:0] y;
      logic                copy;
      logic                last;
      sample_type          t1;
      sample_type          t2;
      sample_type          t3;
      sample_type          m0;
      sample_type          g0;
      sample_type          b0;
      sample_type          m3;
      sample_type          n0;
      sample_type          rr;
      sample_type          g3;
      sample_type          n3;
      sample_type          u0;
      sample_type          u1;
      sample_type          u2;
   } cell_type;

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic                  not_empty;
   } queue_status_type;

   // Low bit cleared, then clamped to [2, lim].
   function automatic logic [DimWidth-1:0] eff_dim(input logic [DimWidth-1:0] v,
                                                   input logic [DimWidth-1:0] lim);
      logic [DimWidth-1:0] e;
      e = {v[DimWidth-1:1], 1'b0};
      if (e < DimWidth'(2)) begin
         e = DimWidth'(2);
      end
      if (e > lim) begin
         e = lim;
      end
      return e;
   endfunction

endpackage

[src/dmsc_req_if.sv]
interface dmsc_req_if;
   import dmsc_pkg::*;

   logic       valid;
   logic       ready;
   sample_type raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink (input valid, input raw_sample, output ready);
endinterface

[src/dmsc_rsp_if.sv]
interface dmsc_rsp_if;
   import dmsc_pkg::*;

   logic                valid;
   logic                ready;
   logic [ColWidth-1:0] pixel_column;
   logic [RowWidth-1:0] pixel_row;
   sample_type          red;
   sample_type          green;
   sample_type          blue;
   logic                frame_end;

   modport source (output valid, output pixel_column, output pixel_row, output red,
                   output green, output blue, output frame_end, input ready);
   modport sink (input valid, input pixel_column, input pixel_row, input red,
                 input green, input blue, input frame_end, output ready);
endinterface

[src/dmsc_csr_if.sv]
interface dmsc_csr_if;
   import dmsc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [DimWidth-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[src/bayer_bilinear_demosaic_core.sv]
// Bilinear demosaic of an 8-bit GBRG mosaic streamed in raster order.
// req_bus carries one raw sample per transaction; rsp_bus carries RGB pixels
// with their column, row and a frame_end flag on the frame's last pixel.
// csr_bus writes frame_width (index 0) and frame_height (index 1); a write to
// either restarts the frame at column 0, row 0. Write only while idle.
// Each odd-column sample that completes a 2x2 cell yields four pixels in the
// order (x,y), (x+1,y), (x,y+1), (x+1,y+1); other samples yield none.
// Path: the completing sample's transaction passes the b and c stages and the
// cell queue before the first pixel of its cell leaves the rsp register.
// Throughput: the pixel generator emits one pixel per cycle while rsp accepts,
// 4 per cell; up to 4 cells queue, letting bursts enter at one sample per
// cycle. req ready drops once the queue cannot hold every cell in flight,
// so an rsp stall backs up to req.
// Reset clears the position counters and sets the geometry to 640x480.
// The four line stores are not cleared; a cell only reads samples of the
// current frame.
module bayer_bilinear_demosaic_core (
   input logic         clock,
   input logic         reset,
   dmsc_req_if.sink    req_bus,
   dmsc_rsp_if.source  rsp_bus,
   dmsc_csr_if.sink    csr_bus
);
   import dmsc_pkg::*;

   logic             push, pop;
   cell_type         push_cell, head;
   queue_status_type q_status;

   dmsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .q_status  (q_status),
      .push      (push),
      .push_cell (push_cell)
   );

   dmsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cell (push_cell),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   dmsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

[src/dmsc_ram.sv]
module dmsc_ram #(
   parameter int Width = 8,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/dmsc_queue.sv]
module dmsc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dmsc_pkg::cell_type         push_cell,
   input  logic                       pop,
   output dmsc_pkg::cell_type         head,
   output dmsc_pkg::queue_status_type q_status
);
   import dmsc_pkg::*;

   cell_type              entries_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cell;
      end
   end

   assign head               = entries_ff[rd_ptr_ff];
   assign q_status.count     = count_ff;
   assign q_status.not_empty = (count_ff != '0);

   assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CountWidth'(QueueDepth)) || pop)
      else $error("cell pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("cell popped from an empty queue");

endmodule

[src/dmsc_front.sv]
module dmsc_front (
   input  logic                       clock,
   input  logic                       reset,
   dmsc_req_if.sink                   req_bus,
   dmsc_csr_if.sink                   csr_bus,
   input  dmsc_pkg::queue_status_type q_status,
   output logic                       push,
   output dmsc_pkg::cell_type         push_cell
);
   import dmsc_pkg::*;

   typedef struct packed {
      logic                emit;
      logic                interior;
      logic [ColWidth-1:0] x;
      logic [RowWidth-1:0] y;
      logic                copy;
      logic                last;
   } meta_type;

   logic [DimWidth-1:0]  width_ff, width_in, height_ff, height_in;
   logic [DimWidth-1:0]  w_eff, h_eff;
   logic [ColWidth-1:0]  col_ff, col_in, next_col;
   logic [RowWidth-1:0]  row_ff, row_in, next_row;
   logic [DimWidth-1:0]  col_inc, row_inc, x_edge, y_edge;
   logic                 last_col, last_row, emit_now;
   logic                 accept, csr_write, csr_hit;
   logic [RowWidth-1:0]  y_even;
   meta_type             meta_a, meta_b_ff, meta_c_ff;
   logic                 vb_ff, vc_ff;
   sample_type           sample_b_ff;
   logic [SlotWidth-1:0] slot_b_ff, slot_m1, slot_0, slot_1;
   sample_type           rd_data [LineSlots];
   sample_type           win_m1_ff [WinCols];
   sample_type           win_0_ff [WinCols];
   sample_type           win_1_ff [WinCols];
   sample_type           cur_ff [CurCols];
   logic [CountWidth:0]  credit_sum;

   assign w_eff = eff_dim(width_ff, DimWidth'(MaxWidth));
   assign h_eff = eff_dim(height_ff, DimWidth'(MaxHeight));

   // Config port
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;
   assign csr_hit       = csr_write && (csr_bus.index == CSR_FRAME_WIDTH ||
                                        csr_bus.index == CSR_FRAME_HEIGHT);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write && csr_bus.index == CSR_FRAME_WIDTH) begin
         width_in = csr_bus.data;
      end
      if (csr_write && csr_bus.index == CSR_FRAME_HEIGHT) begin
         height_in = csr_bus.data;
      end
   end

   // Raster position and cell classification
   assign col_inc  = {1'b0, col_ff} + DimWidth'(1);
   assign row_inc  = {1'b0, row_ff} + DimWidth'(1);
   assign last_col = (col_inc == w_eff);
   assign last_row = (row_inc == h_eff);
   assign next_col = last_col ? '0 : col_inc[ColWidth-1:0];
   assign next_row = last_col ? (last_row ? '0 : row_inc[RowWidth-1:0]) : row_ff;

   assign emit_now = col_ff[0] && ((!row_ff[0] && row_ff[RowWidth-1:1] != '0) ||
                                   (row_ff[0] && last_row));

   assign y_even = {row_ff[RowWidth-1:1], 1'b0};

   always_comb begin
      meta_a.emit     = emit_now;
      meta_a.interior = !row_ff[0];
      meta_a.x        = {col_ff[ColWidth-1:1], 1'b0};
      meta_a.y        = row_ff[0] ? y_even : y_even - RowWidth'(2);
      x_edge          = {1'b0, meta_a.x} + DimWidth'(2);
      y_edge          = {1'b0, meta_a.y} + DimWidth'(2);
      meta_a.copy     = (meta_a.x == '0) || (meta_a.y == '0) ||
                        (x_edge == w_eff) || (y_edge == h_eff);
      meta_a.last     = (x_edge == w_eff) && (y_edge == h_eff);
   end

   // Admit a sample only if every cell in flight has a queue slot
   assign credit_sum = (CountWidth + 1)'(q_status.count)
                     + (CountWidth + 1)'(vb_ff && meta_b_ff.emit)
                     + (CountWidth + 1)'(vc_ff && meta_c_ff.emit)
                     + (CountWidth + 1)'(emit_now);
   assign req_bus.ready = (credit_sum <= (CountWidth + 1)'(QueueDepth));
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         col_in = next_col;
         row_in = next_row;
      end
   end

   // Line stores: write current sample, read the next column of all rows
   for (genvar s = 0; s < LineSlots; s++) begin : g_line
      dmsc_ram #(
         .Width (SampleWidth),
         .Depth (MaxWidth)
      ) u_ram (
         .clock (clock),
         .we    (accept && row_ff[SlotWidth-1:0] == SlotWidth'(s)),
         .waddr (col_ff),
         .wdata (req_bus.raw_sample),
         .re    (accept),
         .raddr (next_col),
         .rdata (rd_data[s])
      );
   end

   // Rows above the next sample's row, relative to its slot
   assign slot_m1 = slot_b_ff + SlotWidth'(1);
   assign slot_0  = slot_b_ff + SlotWidth'(2);
   assign slot_1  = slot_b_ff + SlotWidth'(3);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthReset;
         height_ff <= HeightReset;
         col_ff    <= '0;
         row_ff    <= '0;
         vb_ff     <= 1'b0;
         vc_ff     <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         vb_ff     <= accept;
         vc_ff     <= vb_ff;
      end
      if (accept) begin
         meta_b_ff   <= meta_a;
         sample_b_ff <= req_bus.raw_sample;
         slot_b_ff   <= next_row[SlotWidth-1:0];
      end
      if (vb_ff) begin
         meta_c_ff <= meta_b_ff;
         for (int i = 0; i < WinCols - 1; i++) begin
            win_m1_ff[i] <= win_m1_ff[i+1];
            win_0_ff[i]  <= win_0_ff[i+1];
            win_1_ff[i]  <= win_1_ff[i+1];
         end
         win_m1_ff[WinCols-1] <= rd_data[slot_m1];
         win_0_ff[WinCols-1]  <= rd_data[slot_0];
         win_1_ff[WinCols-1]  <= rd_data[slot_1];
         for (int i = 0; i < CurCols - 1; i++) begin
            cur_ff[i] <= cur_ff[i+1];
         end
         cur_ff[CurCols-1] <= sample_b_ff;
      end
   end

   // Window columns: 0 = x-1, 1 = x, 2 = x+1, 3 = x+2
   assign push = vc_ff && meta_c_ff.emit;

   always_comb begin
      push_cell.x    = meta_c_ff.x;
      push_cell.y    = meta_c_ff.y;
      push_cell.copy = meta_c_ff.copy;
      push_cell.last = meta_c_ff.last;
      push_cell.t1   = win_m1_ff[1];
      push_cell.t2   = win_m1_ff[2];
      push_cell.t3   = win_m1_ff[3];
      push_cell.m0   = win_0_ff[0];
      push_cell.m3   = win_0_ff[3];
      push_cell.n0   = win_1_ff[0];
      push_cell.n3   = win_1_ff[3];
      push_cell.u0   = cur_ff[0];
      push_cell.u1   = cur_ff[1];
      push_cell.u2   = cur_ff[2];
      if (meta_c_ff.interior) begin
         push_cell.g0 = win_0_ff[1];
         push_cell.b0 = win_0_ff[2];
         push_cell.rr = win_1_ff[1];
         push_cell.g3 = win_1_ff[2];
      end else begin
         // last row pair: cell rows are the previous row and this one
         push_cell.g0 = win_1_ff[1];
         push_cell.b0 = win_1_ff[2];
         push_cell.rr = cur_ff[1];
         push_cell.g3 = cur_ff[2];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> col_ff == '0 && row_ff == '0)
      else $error("geometry write did not restart the frame");

   assert property (@(posedge clock) disable iff (reset)
      ((CountWidth + 1)'(q_status.count) + (CountWidth + 1)'(vb_ff && meta_b_ff.emit)
       + (CountWidth + 1)'(vc_ff && meta_c_ff.emit)) <= (CountWidth + 1)'(QueueDepth))
      else $error("cells in flight exceed queue space");

endmodule

[src/dmsc_back.sv]
module dmsc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dmsc_pkg::queue_status_type q_status,
   input  dmsc_pkg::cell_type         head,
   output logic                       pop,
   dmsc_rsp_if.source                 rsp_bus
);
   import dmsc_pkg::*;

   function automatic sample_type avg2(input sample_type a, input sample_type b);
      logic [SampleWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SampleWidth:1];
   endfunction

   function automatic sample_type avg4(input sample_type a, input sample_type b,
                                       input sample_type c, input sample_type d);
      logic [SampleWidth+1:0] s;
      s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
      return s[SampleWidth+1:2];
   endfunction

   logic [1:0]          k_ff, k_in;
   logic                out_valid_ff, out_valid_in;
   logic                load;
   sample_type          red_px, green_px, blue_px, green_mid;
   logic [ColWidth-1:0] col_ff;
   logic [RowWidth-1:0] row_ff;
   sample_type          red_ff, green_ff, blue_ff;
   logic                frame_end_ff;

   assign load = q_status.not_empty && (!out_valid_ff || rsp_bus.ready);
   assign pop  = load && (k_ff == 2'd3);

   assign green_mid = avg2(head.g0, head.g3);

   always_comb begin
      if (head.copy) begin
         red_px  = head.rr;
         blue_px = head.b0;
         unique case (k_ff)
            2'd0: green_px = head.g0;
            2'd1: green_px = green_mid;
            2'd2: green_px = green_mid;
            2'd3: green_px = head.g3;
            default: green_px = head.g3;
         endcase
      end else begin
         unique case (k_ff)
            2'd0: begin
               red_px   = avg2(head.rr, head.t1);
               green_px = head.g0;
               blue_px  = avg2(head.m0, head.b0);
            end
            2'd1: begin
               red_px   = avg4(head.rr, head.n3, head.t1, head.t3);
               green_px = avg4(head.g0, head.m3, head.t2, head.g3);
               blue_px  = head.b0;
            end
            2'd2: begin
               red_px   = head.rr;
               green_px = avg4(head.g0, head.u1, head.n0, head.g3);
               blue_px  = avg4(head.b0, head.m0, head.u2, head.u0);
            end
            default: begin
               red_px   = avg2(head.rr, head.n3);
               green_px = head.g3;
               blue_px  = avg2(head.b0, head.u2);
            end
         endcase
      end
   end

   always_comb begin
      k_in         = load ? k_ff + 2'd1 : k_ff;
      out_valid_in = load ? 1'b1 : (out_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         col_ff       <= {head.x[ColWidth-1:1], k_ff[0]};
         row_ff       <= {head.y[RowWidth-1:1], k_ff[1]};
         red_ff       <= red_px;
         green_ff     <= green_px;
         blue_ff      <= blue_px;
         frame_end_ff <= head.last && (k_ff == 2'd3);
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_column = col_ff;
   assign rsp_bus.pixel_row    = row_ff;
   assign rsp_bus.red          = red_ff;
   assign rsp_bus.green        = green_ff;
   assign rsp_bus.blue         = blue_ff;
   assign rsp_bus.frame_end    = frame_end_ff;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && frame_end_ff) |-> (col_ff[0] && row_ff[0]))
      else $error("frame end flagged on a pixel that is not a cell's last");

endmodule
